FILE: hdl/ctp_pkg.sv
// shared types, widths, result codes and saturation for the circle tangent point unit
// no dependencies
package ctp_pkg;

    localparam int COORD_W = 32;
    localparam int RAD_W   = 31;
    localparam int TOL_W   = 16;
    localparam int VEC_W   = COORD_W + 1;
    localparam int D2_W    = 2 * VEC_W;
    localparam int ROOT_W  = D2_W / 2 + 1;
    localparam int RR_W    = 2 * RAD_W;
    localparam int RS_W    = 64;
    localparam int PART_W  = VEC_W + 32;
    localparam int TERM_W  = PART_W + 33;
    localparam int NUM_W   = TERM_W + 2;
    localparam int QUO_W   = 33;
    localparam int SUM_W   = COORD_W + 3;
    localparam int LANES   = 4;

    localparam logic [1:0] CNT_INSIDE  = 2'd0;
    localparam logic [1:0] CNT_ON      = 2'd1;
    localparam logic [1:0] CNT_OUTSIDE = 2'd2;

    typedef struct packed {
        logic signed [COORD_W-1:0] center_x;
        logic signed [COORD_W-1:0] center_y;
        logic        [RAD_W-1:0]   radius;
        logic signed [COORD_W-1:0] query_x;
        logic signed [COORD_W-1:0] query_y;
    } t_in_item;

    typedef struct packed {
        logic        [1:0]         tangent_count;
        logic signed [COORD_W-1:0] first_x;
        logic signed [COORD_W-1:0] first_y;
        logic signed [COORD_W-1:0] second_x;
        logic signed [COORD_W-1:0] second_y;
    } t_out_item;

    typedef struct packed {
        logic        [1:0]         count;
        logic        [D2_W-1:0]    d2;
        logic        [RR_W-1:0]    rr;
        logic        [RAD_W-1:0]   r;
        logic        [VEC_W-1:0]   ax;
        logic        [VEC_W-1:0]   ay;
        logic                      sx;
        logic                      sy;
        logic signed [COORD_W-1:0] px;
        logic signed [COORD_W-1:0] py;
        logic signed [COORD_W-1:0] onx;
        logic signed [COORD_W-1:0] ony;
    } t_sq_side;

    typedef struct packed {
        logic        [1:0]         count;
        logic signed [COORD_W-1:0] px;
        logic signed [COORD_W-1:0] py;
        logic signed [COORD_W-1:0] onx;
        logic signed [COORD_W-1:0] ony;
        logic        [LANES-1:0]   neg;
    } t_dv_side;

    function automatic logic signed [COORD_W-1:0] sat_coord(input logic signed [SUM_W-1:0] v);
        logic hi_ones;
        logic hi_zeros;
        hi_ones  = &v[SUM_W-1:COORD_W-1];
        hi_zeros = ~|v[SUM_W-1:COORD_W-1];
        if (hi_ones || hi_zeros) begin
            return v[COORD_W-1:0];
        end else if (v[SUM_W-1]) begin
            return {1'b1, {(COORD_W-1){1'b0}}};
        end else begin
            return {1'b0, {(COORD_W-1){1'b1}}};
        end
    endfunction

endpackage

FILE: hdl/ctp_in_if.sv
// input channel of the circle tangent point unit: valid, ready and one query
// depends on ctp_pkg
interface ctp_in_if import ctp_pkg::*; ();
    logic     valid;
    logic     ready;
    t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

FILE: hdl/ctp_out_if.sv
// output channel of the circle tangent point unit: valid, ready and one result
// depends on ctp_pkg
interface ctp_out_if import ctp_pkg::*; ();
    logic      valid;
    logic      ready;
    t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

FILE: hdl/ctp_sqrt.sv
// pipelined floor square root, one root bit per stage, with a sideband that travels along
// depends on ctp_pkg
module ctp_sqrt import ctp_pkg::*; #(
    parameter int XW = D2_W,
    parameter int RW = ROOT_W,
    parameter int SW = 1
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  logic [XW-1:0] i_x,
    input  logic [SW-1:0] i_side,
    output logic          o_valid,
    input  logic          i_ready,
    output logic [RW-1:0] o_root,
    output logic [SW-1:0] o_side
);

    localparam int EW = 2 * RW + 1;

    logic [RW-1:0] r_v;
    logic [EW-1:0] r_rem  [RW];
    logic [RW-1:0] r_res  [RW];
    logic [SW-1:0] r_side [RW];

    logic [RW:0]   w_en;
    logic [RW-1:0] w_v_in;
    logic [EW-1:0] w_rem_in  [RW];
    logic [RW-1:0] w_res_in  [RW];
    logic [SW-1:0] w_side_in [RW];
    logic [EW-1:0] w_trial   [RW];
    logic [EW-1:0] n_rem     [RW];
    logic [RW-1:0] n_res     [RW];

    assign w_v_in = {r_v[RW-2:0], i_valid};

    always_comb begin
        w_rem_in[0]  = EW'(i_x);
        w_res_in[0]  = '0;
        w_side_in[0] = i_side;
        for (int k = 1; k < RW; k++) begin
            w_rem_in[k]  = r_rem[k-1];
            w_res_in[k]  = r_res[k-1];
            w_side_in[k] = r_side[k-1];
        end
    end

    // trial = (res + 2^b)^2 - res^2
    always_comb begin
        for (int k = 0; k < RW; k++) begin
            w_trial[k] = (EW'(w_res_in[k]) << (RW - k)) | (EW'(1) << (2 * (RW - 1 - k)));
            if (w_rem_in[k] >= w_trial[k]) begin
                n_rem[k] = w_rem_in[k] - w_trial[k];
                n_res[k] = w_res_in[k] | (RW'(1) << (RW - 1 - k));
            end else begin
                n_rem[k] = w_rem_in[k];
                n_res[k] = w_res_in[k];
            end
        end
    end

    assign w_en[RW] = i_ready;

    genvar g;
    generate
        for (g = 0; g < RW; g++) begin : g_en
            assign w_en[g] = !r_v[g] || w_en[g+1];
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            for (int k = 0; k < RW; k++) begin
                if (w_en[k]) begin
                    r_v[k] <= w_v_in[k];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < RW; k++) begin
            if (w_en[k]) begin
                r_rem[k]  <= n_rem[k];
                r_res[k]  <= n_res[k];
                r_side[k] <= w_side_in[k];
            end
        end
    end

    assign o_ready = w_en[0];
    assign o_valid = r_v[RW-1];
    assign o_root  = r_res[RW-1];
    assign o_side  = r_side[RW-1];

endmodule

FILE: hdl/ctp_div.sv
// pipelined restoring divider, one quotient bit per stage, several numerators over one divisor
// depends on ctp_pkg
module ctp_div import ctp_pkg::*; #(
    parameter int NW = NUM_W,
    parameter int DW = D2_W,
    parameter int QW = QUO_W,
    parameter int LN = LANES,
    parameter int SW = 1
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_ready,
    input  logic [LN-1:0][NW-1:0]  i_num,
    input  logic [DW-1:0]          i_den,
    input  logic [SW-1:0]          i_side,
    output logic                   o_valid,
    input  logic                   i_ready,
    output logic [LN-1:0][QW-1:0]  o_quo,
    output logic [SW-1:0]          o_side
);

    logic [QW-1:0]         r_v;
    logic [LN-1:0][NW-1:0] r_rem  [QW];
    logic [LN-1:0][QW-1:0] r_quo  [QW];
    logic [DW-1:0]         r_den  [QW];
    logic [SW-1:0]         r_side [QW];

    logic [QW:0]           w_en;
    logic [QW-1:0]         w_v_in;
    logic [LN-1:0][NW-1:0] w_rem_in  [QW];
    logic [LN-1:0][QW-1:0] w_quo_in  [QW];
    logic [DW-1:0]         w_den_in  [QW];
    logic [SW-1:0]         w_side_in [QW];
    logic [NW-1:0]         w_dsh     [QW];
    logic [LN-1:0][NW-1:0] n_rem     [QW];
    logic [LN-1:0][QW-1:0] n_quo     [QW];

    assign w_v_in = {r_v[QW-2:0], i_valid};

    always_comb begin
        w_rem_in[0]  = i_num;
        w_quo_in[0]  = '0;
        w_den_in[0]  = i_den;
        w_side_in[0] = i_side;
        for (int k = 1; k < QW; k++) begin
            w_rem_in[k]  = r_rem[k-1];
            w_quo_in[k]  = r_quo[k-1];
            w_den_in[k]  = r_den[k-1];
            w_side_in[k] = r_side[k-1];
        end
    end

    always_comb begin
        for (int k = 0; k < QW; k++) begin
            w_dsh[k] = {{(NW-DW){1'b0}}, w_den_in[k]} << (QW - 1 - k);
            for (int l = 0; l < LN; l++) begin
                if (w_rem_in[k][l] >= w_dsh[k]) begin
                    n_rem[k][l] = w_rem_in[k][l] - w_dsh[k];
                    n_quo[k][l] = w_quo_in[k][l] | (QW'(1) << (QW - 1 - k));
                end else begin
                    n_rem[k][l] = w_rem_in[k][l];
                    n_quo[k][l] = w_quo_in[k][l];
                end
            end
        end
    end

    assign w_en[QW] = i_ready;

    genvar g;
    generate
        for (g = 0; g < QW; g++) begin : g_en
            assign w_en[g] = !r_v[g] || w_en[g+1];
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            for (int k = 0; k < QW; k++) begin
                if (w_en[k]) begin
                    r_v[k] <= w_v_in[k];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < QW; k++) begin
            if (w_en[k]) begin
                r_rem[k]  <= n_rem[k];
                r_quo[k]  <= n_quo[k];
                r_den[k]  <= w_den_in[k];
                r_side[k] <= w_side_in[k];
            end
        end
    end

    assign o_ready = w_en[0];
    assign o_valid = r_v[QW-1];
    assign o_quo   = r_quo[QW-1];
    assign o_side  = r_side[QW-1];

endmodule

FILE: hdl/circle_tangent_points_unit.sv
// Tangent points from a query point to a circle, fully pipelined: one transaction can enter
// every clock and each result passes through 3 setup stages, a 34-stage square root
// that settles one root bit per stage, 5 product and sum stages, a 33-stage divider that
// settles one quotient bit per stage for all four coordinates, and the output register.
// Sustained rate is one transaction per cycle; a stalled output holds the pipe and empty
// stages close up behind it. The tolerance register is written through i_cfg_we/i_cfg_wdata.
// depends on ctp_pkg, ctp_in_if, ctp_out_if, ctp_sqrt, ctp_div
module circle_tangent_points_unit import ctp_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [TOL_W-1:0] i_cfg_wdata,
    ctp_in_if.sink           i_in,
    ctp_out_if.source        o_out
);

    localparam int SQ_SW = $bits(t_sq_side);
    localparam int DV_SW = $bits(t_dv_side);

    function automatic logic [NUM_W:0] sm_add(input logic [TERM_W-1:0] a,
                                              input logic [TERM_W-1:0] b,
                                              input logic sa, input logic sb);
        logic [NUM_W-1:0] sum;
        logic [NUM_W-1:0] dab;
        logic [NUM_W-1:0] dba;
        sum = NUM_W'(a) + NUM_W'(b);
        dab = NUM_W'(a) - NUM_W'(b);
        dba = NUM_W'(b) - NUM_W'(a);
        if (sa == sb) begin
            return {sa, sum};
        end else if (a >= b) begin
            return {sa, dab};
        end else begin
            return {sb, dba};
        end
    endfunction

    logic [TOL_W-1:0] r_tol;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tol <= '0;
        end else if (i_cfg_we) begin
            r_tol <= i_cfg_wdata;
        end
    end

    // stage enables
    logic w_en_1, w_en_2, w_en_3, w_en_a, w_en_b, w_en_c, w_en_d, w_en_e, w_en_f;
    logic w_sq_rdy, w_sq_v, w_dv_rdy, w_dv_v;
    logic r1_v, r2_v, r3_v, ra_v, rb_v, rc_v, rd_v, re_v, r_out_v;

    assign w_en_3 = !r3_v || w_sq_rdy;
    assign w_en_2 = !r2_v || w_en_3;
    assign w_en_1 = !r1_v || w_en_2;
    assign w_en_f = !r_out_v || o_out.ready;
    assign w_en_e = !re_v || w_dv_rdy;
    assign w_en_d = !rd_v || w_en_e;
    assign w_en_c = !rc_v || w_en_d;
    assign w_en_b = !rb_v || w_en_c;
    assign w_en_a = !ra_v || w_en_b;
    assign i_in.ready = w_en_1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v    <= 1'b0;
            r2_v    <= 1'b0;
            r3_v    <= 1'b0;
            ra_v    <= 1'b0;
            rb_v    <= 1'b0;
            rc_v    <= 1'b0;
            rd_v    <= 1'b0;
            re_v    <= 1'b0;
            r_out_v <= 1'b0;
        end else begin
            if (w_en_1) begin
                r1_v <= i_in.valid;
            end
            if (w_en_2) begin
                r2_v <= r1_v;
            end
            if (w_en_3) begin
                r3_v <= r2_v;
            end
            if (w_en_a) begin
                ra_v <= w_sq_v;
            end
            if (w_en_b) begin
                rb_v <= ra_v;
            end
            if (w_en_c) begin
                rc_v <= rb_v;
            end
            if (w_en_d) begin
                rd_v <= rc_v;
            end
            if (w_en_e) begin
                re_v <= rd_v;
            end
            if (w_en_f) begin
                r_out_v <= w_dv_v;
            end
        end
    end

    // stage 1: offset vector, its magnitudes, band limits
    logic signed [VEC_W-1:0]   w_vx, w_vy;
    logic        [VEC_W-1:0]   w_ax, w_ay;
    logic signed [VEC_W-1:0]   r1_vx, r1_vy;
    logic        [VEC_W-1:0]   r1_ax, r1_ay;
    logic signed [COORD_W-1:0] r1_px, r1_py, r1_qx, r1_qy;
    logic        [RAD_W-1:0]   r1_r, r1_inner;
    logic                      r1_inpos;
    logic        [RAD_W:0]     r1_outer;

    assign w_vx = VEC_W'(i_in.data.query_x) - VEC_W'(i_in.data.center_x);
    assign w_vy = VEC_W'(i_in.data.query_y) - VEC_W'(i_in.data.center_y);
    assign w_ax = w_vx[VEC_W-1] ? VEC_W'(-w_vx) : VEC_W'(w_vx);
    assign w_ay = w_vy[VEC_W-1] ? VEC_W'(-w_vy) : VEC_W'(w_vy);

    always_ff @(posedge i_clk) begin
        if (w_en_1) begin
            r1_vx    <= w_vx;
            r1_vy    <= w_vy;
            r1_ax    <= w_ax;
            r1_ay    <= w_ay;
            r1_px    <= i_in.data.center_x;
            r1_py    <= i_in.data.center_y;
            r1_qx    <= i_in.data.query_x;
            r1_qy    <= i_in.data.query_y;
            r1_r     <= i_in.data.radius;
            r1_inner <= i_in.data.radius - RAD_W'(r_tol);
            r1_inpos <= i_in.data.radius > RAD_W'(r_tol);
            r1_outer <= (RAD_W+1)'(i_in.data.radius) + (RAD_W+1)'(r_tol);
        end
    end

    // stage 2: squares and the saturated on-circle point
    logic        [D2_W-1:0]      w_ax2, w_ay2;
    logic        [RR_W-1:0]      w_in2, w_rr;
    logic        [2*RAD_W+1:0]   w_out2;
    logic signed [SUM_W-1:0]     w_onx, w_ony;
    logic        [D2_W-1:0]      r2_ax2, r2_ay2;
    logic        [RR_W-1:0]      r2_in2, r2_rr;
    logic        [2*RAD_W+1:0]   r2_out2;
    logic signed [COORD_W-1:0]   r2_onx, r2_ony, r2_px, r2_py;
    logic        [RAD_W-1:0]     r2_r;
    logic        [VEC_W-1:0]     r2_ax, r2_ay;
    logic                        r2_sx, r2_sy, r2_inpos;

    assign w_ax2  = r1_ax * r1_ax;
    assign w_ay2  = r1_ay * r1_ay;
    assign w_in2  = r1_inner * r1_inner;
    assign w_out2 = r1_outer * r1_outer;
    assign w_rr   = r1_r * r1_r;
    assign w_onx  = SUM_W'(r1_qx) - SUM_W'(r1_vy);
    assign w_ony  = SUM_W'(r1_qy) + SUM_W'(r1_vx);

    always_ff @(posedge i_clk) begin
        if (w_en_2) begin
            r2_ax2   <= w_ax2;
            r2_ay2   <= w_ay2;
            r2_in2   <= w_in2;
            r2_out2  <= w_out2;
            r2_rr    <= w_rr;
            r2_onx   <= sat_coord(w_onx);
            r2_ony   <= sat_coord(w_ony);
            r2_px    <= r1_px;
            r2_py    <= r1_py;
            r2_r     <= r1_r;
            r2_ax    <= r1_ax;
            r2_ay    <= r1_ay;
            r2_sx    <= r1_vx[VEC_W-1];
            r2_sy    <= r1_vy[VEC_W-1];
            r2_inpos <= r1_inpos;
        end
    end

    // stage 3: squared distance and classification
    logic [D2_W-1:0] w_d2, w_dr;
    logic [1:0]      w_cnt;
    logic [D2_W-1:0] r3_dr;
    t_sq_side        r3_side;

    assign w_d2 = r2_ax2 + r2_ay2;
    assign w_dr = r2_ax2 + r2_ay2 - D2_W'(r2_rr);

    always_comb begin
        if (r2_inpos && (w_d2 < D2_W'(r2_in2))) begin
            w_cnt = CNT_INSIDE;
        end else if (w_d2 <= D2_W'(r2_out2)) begin
            w_cnt = CNT_ON;
        end else begin
            w_cnt = CNT_OUTSIDE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en_3) begin
            r3_dr         <= w_dr;
            r3_side.count <= w_cnt;
            r3_side.d2    <= w_d2;
            r3_side.rr    <= r2_rr;
            r3_side.r     <= r2_r;
            r3_side.ax    <= r2_ax;
            r3_side.ay    <= r2_ay;
            r3_side.sx    <= r2_sx;
            r3_side.sy    <= r2_sy;
            r3_side.px    <= r2_px;
            r3_side.py    <= r2_py;
            r3_side.onx   <= r2_onx;
            r3_side.ony   <= r2_ony;
        end
    end

    logic [ROOT_W-1:0] w_root;
    logic [SQ_SW-1:0]  w_sq_side_vec;
    t_sq_side          w_sq_side;

    ctp_sqrt #(
        .XW (D2_W),
        .RW (ROOT_W),
        .SW (SQ_SW)
    ) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r3_v),
        .o_ready (w_sq_rdy),
        .i_x     (r3_dr),
        .i_side  (r3_side),
        .o_valid (w_sq_v),
        .i_ready (w_en_a),
        .o_root  (w_root),
        .o_side  (w_sq_side_vec)
    );

    assign w_sq_side = w_sq_side_vec;

    // stage a: r * s
    logic [RAD_W+ROOT_W-1:0] w_rs_full;
    logic [RS_W-1:0]         ra_rs;
    t_sq_side                ra_side;

    assign w_rs_full = w_sq_side.r * w_root;

    always_ff @(posedge i_clk) begin
        if (w_en_a) begin
            ra_rs   <= w_rs_full[RS_W-1:0];
            ra_side <= w_sq_side;
        end
    end

    // stage b: partial products on 32-bit halves
    logic [PART_W-1:0] w_xr_lo, w_xr_hi, w_yr_lo, w_yr_hi;
    logic [PART_W-1:0] w_xs_lo, w_xs_hi, w_ys_lo, w_ys_hi;
    logic [PART_W-1:0] rb_xr_lo, rb_xr_hi, rb_yr_lo, rb_yr_hi;
    logic [PART_W-1:0] rb_xs_lo, rb_xs_hi, rb_ys_lo, rb_ys_hi;
    t_sq_side          rb_side;

    assign w_xr_lo = ra_side.ax * ra_side.rr[31:0];
    assign w_xr_hi = ra_side.ax * ra_side.rr[RR_W-1:32];
    assign w_yr_lo = ra_side.ay * ra_side.rr[31:0];
    assign w_yr_hi = ra_side.ay * ra_side.rr[RR_W-1:32];
    assign w_xs_lo = ra_side.ax * ra_rs[31:0];
    assign w_xs_hi = ra_side.ax * ra_rs[RS_W-1:32];
    assign w_ys_lo = ra_side.ay * ra_rs[31:0];
    assign w_ys_hi = ra_side.ay * ra_rs[RS_W-1:32];

    always_ff @(posedge i_clk) begin
        if (w_en_b) begin
            rb_xr_lo <= w_xr_lo;
            rb_xr_hi <= w_xr_hi;
            rb_yr_lo <= w_yr_lo;
            rb_yr_hi <= w_yr_hi;
            rb_xs_lo <= w_xs_lo;
            rb_xs_hi <= w_xs_hi;
            rb_ys_lo <= w_ys_lo;
            rb_ys_hi <= w_ys_hi;
            rb_side  <= ra_side;
        end
    end

    // stage c: full term magnitudes
    logic [TERM_W-1:0] rc_xr, rc_yr, rc_xs, rc_ys;
    t_sq_side          rc_side;

    always_ff @(posedge i_clk) begin
        if (w_en_c) begin
            rc_xr   <= TERM_W'(rb_xr_lo) + (TERM_W'(rb_xr_hi) << 32);
            rc_yr   <= TERM_W'(rb_yr_lo) + (TERM_W'(rb_yr_hi) << 32);
            rc_xs   <= TERM_W'(rb_xs_lo) + (TERM_W'(rb_xs_hi) << 32);
            rc_ys   <= TERM_W'(rb_ys_lo) + (TERM_W'(rb_ys_hi) << 32);
            rc_side <= rb_side;
        end
    end

    // stage d: signed sums, lanes first_x, first_y, second_x, second_y
    logic [NUM_W:0]     w_sm [LANES];
    logic [NUM_W-1:0]   rd_mag [LANES];
    logic [LANES-1:0]   rd_neg;
    t_sq_side           rd_side;

    always_comb begin
        w_sm[0] = sm_add(rc_xr, rc_ys, rc_side.sx, !rc_side.sy);
        w_sm[1] = sm_add(rc_yr, rc_xs, rc_side.sy, rc_side.sx);
        w_sm[2] = sm_add(rc_xr, rc_ys, rc_side.sx, rc_side.sy);
        w_sm[3] = sm_add(rc_yr, rc_xs, rc_side.sy, !rc_side.sx);
    end

    always_ff @(posedge i_clk) begin
        if (w_en_d) begin
            for (int l = 0; l < LANES; l++) begin
                rd_mag[l] <= w_sm[l][NUM_W-1:0];
                rd_neg[l] <= w_sm[l][NUM_W];
            end
            rd_side <= rc_side;
        end
    end

    // stage e: add half the divisor for rounding
    logic [LANES-1:0][NUM_W-1:0] re_num;
    logic [D2_W-1:0]             re_d2;
    t_dv_side                    re_side;

    always_ff @(posedge i_clk) begin
        if (w_en_e) begin
            for (int l = 0; l < LANES; l++) begin
                re_num[l] <= rd_mag[l] + NUM_W'(rd_side.d2 >> 1);
            end
            re_d2         <= rd_side.d2;
            re_side.count <= rd_side.count;
            re_side.px    <= rd_side.px;
            re_side.py    <= rd_side.py;
            re_side.onx   <= rd_side.onx;
            re_side.ony   <= rd_side.ony;
            re_side.neg   <= rd_neg;
        end
    end

    logic [LANES-1:0][QUO_W-1:0] w_quo;
    logic [DV_SW-1:0]            w_dv_side_vec;
    t_dv_side                    w_dv_side;

    ctp_div #(
        .NW (NUM_W),
        .DW (D2_W),
        .QW (QUO_W),
        .LN (LANES),
        .SW (DV_SW)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (re_v),
        .o_ready (w_dv_rdy),
        .i_num   (re_num),
        .i_den   (re_d2),
        .i_side  (re_side),
        .o_valid (w_dv_v),
        .i_ready (w_en_f),
        .o_quo   (w_quo),
        .o_side  (w_dv_side_vec)
    );

    assign w_dv_side = w_dv_side_vec;

    // output stage: centre plus signed offset, saturate, select by count
    logic signed [SUM_W-1:0]   w_off [LANES];
    logic signed [SUM_W-1:0]   w_crd [LANES];
    logic signed [COORD_W-1:0] w_sat [LANES];
    t_out_item                 w_item;
    t_out_item                 r_out_item;

    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            w_off[l] = SUM_W'(w_quo[l]);
            if (l % 2 == 0) begin
                w_crd[l] = SUM_W'(w_dv_side.px) + (w_dv_side.neg[l] ? -w_off[l] : w_off[l]);
            end else begin
                w_crd[l] = SUM_W'(w_dv_side.py) + (w_dv_side.neg[l] ? -w_off[l] : w_off[l]);
            end
            w_sat[l] = sat_coord(w_crd[l]);
        end
    end

    always_comb begin
        w_item.tangent_count = w_dv_side.count;
        case (w_dv_side.count)
            CNT_ON: begin
                w_item.first_x  = w_dv_side.onx;
                w_item.first_y  = w_dv_side.ony;
                w_item.second_x = w_dv_side.onx;
                w_item.second_y = w_dv_side.ony;
            end
            CNT_OUTSIDE: begin
                w_item.first_x  = w_sat[0];
                w_item.first_y  = w_sat[1];
                w_item.second_x = w_sat[2];
                w_item.second_y = w_sat[3];
            end
            default: begin
                w_item.first_x  = '0;
                w_item.first_y  = '0;
                w_item.second_x = '0;
                w_item.second_y = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_en_f) begin
            r_out_item <= w_item;
        end
    end

    assign o_out.valid = r_out_v;
    assign o_out.data  = r_out_item;

endmodule

FILE: sim/circle_tangent_points_unit_test.sv
`timescale 1ns / 1ps
// self-checking testbench of circle_tangent_points_unit: directed table, then random queries
// near, inside and outside the circle under several tolerance settings with random flow control
// depends on ctp_pkg, ctp_in_if, ctp_out_if and circle_tangent_points_unit
module circle_tangent_points_unit_test;
    import ctp_pkg::*;

    typedef logic signed [127:0] wide_s;

    typedef struct {
        t_in_item  query;
        bit        typed;
        t_out_item result;
    } t_row;

    localparam int DRAIN_CYCLES = 90;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_cfg_we;
    logic [TOL_W-1:0]    i_cfg_wdata;
    logic [TOL_W-1:0]    tol_shadow;
    t_out_item           expected_points[$];
    int                  mismatch_count;
    int                  result_count;
    int                  sent_count;
    int                  burst_left;
    int                  stall_cycle;
    t_row                rows[11];

    ctp_in_if  in_if ();
    ctp_out_if out_if ();

    circle_tangent_points_unit u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in        (in_if),
        .o_out       (out_if)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic wide_s floor_root(input wide_s x);
        wide_s res;
        wide_s c;
        res = 0;
        for (int b = 33; b >= 0; b--) begin
            c = res | (wide_s'(1) <<< b);
            if (c * c <= x) res = c;
        end
        return res;
    endfunction

    function automatic logic signed [COORD_W-1:0] clamp_coord(input wide_s x);
        if (x > 128'sd2147483647) return 32'sh7fffffff;
        if (x < -128'sd2147483648) return 32'sh80000000;
        return x[COORD_W-1:0];
    endfunction

    // centre + round(n / d2), ties away from zero, offset clipped at 2^40
    function automatic logic signed [COORD_W-1:0] tangent_lane(input wide_s c, input wide_s n,
                                                              input wide_s d2);
        wide_s mag;
        wide_s q;
        mag = (n < 0) ? -n : n;
        q = (mag + (d2 >>> 1)) / d2;
        if (q > (wide_s'(1) <<< 40)) q = wide_s'(1) <<< 40;
        return clamp_coord(c + ((n < 0) ? -q : q));
    endfunction

    function automatic t_out_item tangent_points(input t_in_item it, input logic [TOL_W-1:0] tol);
        t_out_item o;
        wide_s px, py, qx, qy, vx, vy, r, t, d2, r2, s, rs;
        px = wide_s'(it.center_x);
        py = wide_s'(it.center_y);
        qx = wide_s'(it.query_x);
        qy = wide_s'(it.query_y);
        r  = wide_s'({1'b0, it.radius});
        t  = wide_s'({1'b0, tol});
        vx = qx - px;
        vy = qy - py;
        d2 = vx * vx + vy * vy;
        o = '0;
        if (r > t && d2 < (r - t) * (r - t)) begin
            o.tangent_count = CNT_INSIDE;
        end else if (d2 <= (r + t) * (r + t)) begin
            o.tangent_count = CNT_ON;
            o.first_x  = clamp_coord(qx - vy);
            o.first_y  = clamp_coord(qy + vx);
            o.second_x = o.first_x;
            o.second_y = o.first_y;
        end else begin
            r2 = r * r;
            s  = floor_root(d2 - r2);
            rs = wide_s'({64'd0, 64'(r * s)});
            o.tangent_count = CNT_OUTSIDE;
            o.first_x  = tangent_lane(px, vx * r2 - vy * rs, d2);
            o.first_y  = tangent_lane(py, vy * r2 + vx * rs, d2);
            o.second_x = tangent_lane(px, vx * r2 + vy * rs, d2);
            o.second_y = tangent_lane(py, vy * r2 - vx * rs, d2);
        end
        return o;
    endfunction

    task automatic report_field(input string name, input logic [31:0] exp_v,
                                input logic [31:0] act_v);
        if (exp_v !== act_v) begin
            mismatch_count++;
            if (mismatch_count <= 10)
                $display("transaction %0d: %s expected %h got %h", result_count, name,
                         exp_v, act_v);
        end
    endtask

    // receiver: stall pattern steps through four modes, chosen by stall_cycle
    always @(posedge i_clk) begin
        stall_cycle <= stall_cycle + 1;
        case (stall_cycle[10:9])
            2'd0: out_if.ready <= 1'b1;
            2'd1: out_if.ready <= ($urandom_range(0, 9) < 7);
            2'd2: out_if.ready <= (stall_cycle[2:0] != 3'd0);
            default: out_if.ready <= ($urandom_range(0, 3) == 0);
        endcase
    end

    always @(posedge i_clk) begin
        if (i_rst_n && out_if.valid && out_if.ready) begin
            if (expected_points.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10) $display("unexpected transaction %0d", result_count);
            end else begin
                t_out_item e;
                e = expected_points.pop_front();
                report_field("tangent_count", {30'd0, e.tangent_count},
                             {30'd0, out_if.data.tangent_count});
                report_field("first_x", e.first_x, out_if.data.first_x);
                report_field("first_y", e.first_y, out_if.data.first_y);
                report_field("second_x", e.second_x, out_if.data.second_x);
                report_field("second_y", e.second_y, out_if.data.second_y);
            end
            result_count++;
        end
    end

    task automatic send_query(input t_in_item it, input bit typed, input t_out_item result);
        in_if.valid <= 1'b1;
        in_if.data  <= it;
        @(posedge i_clk);
        while (!in_if.ready) @(posedge i_clk);
        expected_points.push_back(typed ? result : tangent_points(it, tol_shadow));
        sent_count++;
        burst_left--;
        if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 40);
            if ($urandom_range(0, 3) != 0) begin
                in_if.valid <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge i_clk);
            end
        end
    endtask

    task automatic wait_idle();
        in_if.valid <= 1'b0;
        @(posedge i_clk);
        while (expected_points.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_tolerance(input logic [TOL_W-1:0] v);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        tol_shadow  = v;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    function automatic t_in_item random_query();
        t_in_item it;
        longint r, vx, vy, cx, cy, j;
        it.center_x = $urandom();
        it.center_y = $urandom();
        it.radius   = RAD_W'($urandom());
        it.query_x  = $urandom();
        it.query_y  = $urandom();
        case ($urandom_range(0, 9))
            0, 1: ;
            2: begin
                it.query_x = it.center_x;
                it.query_y = it.center_y;
            end
            3: it.radius = RAD_W'($urandom_range(0, 3));
            default: begin
                r  = $urandom_range(1, 1 << ($urandom_range(2, 24)));
                vx = longint'($urandom_range(0, 2 * r)) - r;
                vy = longint'(floor_root(wide_s'(r * r - vx * vx)));
                if ($urandom_range(0, 1)) vy = -vy;
                j  = longint'(tol_shadow) + 3;
                vy = vy + longint'($urandom_range(0, 2 * j)) - j;
                cx = longint'($urandom_range(0, 1 << 29)) - (1 << 28);
                cy = longint'($urandom_range(0, 1 << 29)) - (1 << 28);
                it.radius   = RAD_W'(r);
                it.center_x = COORD_W'(cx);
                it.center_y = COORD_W'(cy);
                it.query_x  = COORD_W'(cx + vx);
                it.query_y  = COORD_W'(cy + vy);
            end
        endcase
        return it;
    endfunction

    task automatic random_phase(input int n);
        t_out_item none;
        none = '0;
        repeat (n) send_query(random_query(), 1'b0, none);
    endtask

    initial begin
        t_out_item z;
        z = '0;
        rows[0]  = '{'{0, 0, 0, 0, 0}, 1, '{CNT_ON, 0, 0, 0, 0}};
        rows[1]  = '{'{0, 0, 100, 0, 0}, 1, z};
        rows[2]  = '{'{0, 0, 65536, 65536, 0}, 1, '{CNT_ON, 65536, 65536, 65536, 65536}};
        rows[3]  = '{'{32'h80000000, 32'h80000000, 31'h7fffffff, 32'h7fffffff, 32'h7fffffff},
                     0, z};
        rows[4]  = '{'{32'h7fffffff, 32'h7fffffff, 31'h7fffffff, 32'h80000000, 32'h80000000},
                     0, z};
        rows[5]  = '{'{0, 0, 0, 5, 0}, 0, z};
        rows[6]  = '{'{32'h7fffffff, 32'h7fffffff, 0, 32'h7fffffff, 32'h7fffffff}, 1,
                     '{CNT_ON, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff}};
        rows[7]  = '{'{32'h7fffffff, 32'h7fffffff, 1, 32'h80000000, 32'h80000000}, 0, z};
        rows[8]  = '{'{32'h7fffffff, 32'h7fffffff, 5, 32'h7fffffff, 32'h7ffffffa}, 1,
                     '{CNT_ON, 32'h7fffffff, 32'h7ffffffa, 32'h7fffffff, 32'h7ffffffa}};
        rows[9]  = '{'{0, 0, 31'h7fffffff, 0, 0}, 1, z};
        rows[10] = '{'{0, 0, 65536, 131072, 0}, 0, z};

        i_rst_n        = 1'b0;
        i_cfg_we       = 1'b0;
        i_cfg_wdata    = '0;
        in_if.valid    = 1'b0;
        in_if.data     = '0;
        out_if.ready   = 1'b0;
        tol_shadow     = '0;
        mismatch_count = 0;
        result_count   = 0;
        sent_count     = 0;
        stall_cycle    = 0;
        burst_left     = 8;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (rows[k]) send_query(rows[k].query, rows[k].typed, rows[k].result);
        random_phase(400);
        wait_idle();
        write_tolerance(16'hffff);
        random_phase(500);
        wait_idle();
        write_tolerance(TOL_W'($urandom_range(2, 4000)));
        random_phase(500);
        wait_idle();
        write_tolerance(16'd1);
        random_phase(500);
        wait_idle();

        $display("%0d queries sent, %0d results checked, tolerance 0, 1, 65535 and a random value",
                 sent_count, result_count);
        $display("near-circle, on-centre, zero-radius and full-range queries under stalls");
        if (mismatch_count == 0)
            $display("circle_tangent_points_unit: match");
        else
            $display("circle_tangent_points_unit: mismatch");
        $finish;
    end

    initial begin
        #5_000_000;
        $display("circle_tangent_points_unit: mismatch");
        $finish;
    end
endmodule
